// ===== src/crp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the cadence and power meter
// Widths, command and direction codes, power polynomial coefficients
// (Q24 fixed point) and the control structs between the units.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int unsigned RESISTANCE_MAX = 255;
	localparam int unsigned DURATION_BITS  = 16;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned IN_DUR_W  = 16;
	localparam int unsigned DUR_W     = DURATION_BITS;
	localparam int unsigned RES_W     = $clog2(RESISTANCE_MAX + 1);
	localparam int unsigned RES_OUT_W = 8;
	localparam int unsigned DIR_W     = 2;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned PWR_W     = 16;

	// cadence = RPM_NUM / (high + low)
	localparam int unsigned RPM_W     = 16;
	localparam int unsigned RPM_NUM   = 60000;
	localparam int unsigned DIV_W     = DUR_W + 1;
	localparam int unsigned DIV_CNT_W = $clog2(RPM_W);

	// polynomial datapath
	localparam int unsigned FRAC_BITS = 24;
	localparam int unsigned ACC_W     = 64;
	localparam int unsigned OPA_W     = 2 * RPM_W + 1;
	localparam int unsigned OPB_W     = RES_W + 17;
	localparam int unsigned TMP_W     = OPB_W;
	localparam int unsigned PROD_W    = OPA_W + OPB_W;
	localparam int unsigned QUO_W     = ACC_W - FRAC_BITS;

	localparam logic signed [31:0] C_LR2 = 32'sd1475;
	localparam logic signed [31:0] C_R2  = -32'sd35114;
	localparam logic signed [31:0] C_L2  = 32'sd8561;
	localparam logic signed [31:0] C_LR  = 32'sd1618;
	localparam logic signed [31:0] C_R   = 32'sd7185845;
	localparam logic signed [31:0] C_L   = 32'sd2238896;
	localparam logic signed [31:0] C_C   = 32'sd77556647;

	localparam logic [QUO_W-1:0] PWR_POS_LIM = QUO_W'((64'd1 << (PWR_W - 1)) - 64'd1);
	localparam logic [QUO_W-1:0] PWR_NEG_LIM = QUO_W'(64'd1 << (PWR_W - 1));
	localparam logic signed [PWR_W-1:0] PWR_MAX = PWR_W'(PWR_POS_LIM);
	localparam logic signed [PWR_W-1:0] PWR_MIN = PWR_W'(PWR_NEG_LIM);

	typedef enum logic [CMD_W-1:0] {
		CMD_WHEEL_FELL = 2'd0,
		CMD_WHEEL_ROSE = 2'd1,
		CMD_SWITCH     = 2'd2,
		CMD_MOTOR      = 2'd3
	} cmd_t;

	localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_DIV,
		TS_POLY,
		TS_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_MUL,
		PS_ACC,
		PS_CONST,
		PS_ABS,
		PS_SAT
	} poly_state_t;

	// one multiply/accumulate pair per step
	typedef enum logic [2:0] {
		ST_R2,
		ST_A2,
		ST_T2,
		ST_A1,
		ST_T1,
		ST_A0,
		ST_T0
	} poly_step_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [RPM_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RES_W-1:0] level;
		logic [RPM_W-1:0] rpm;
	} poly_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [PWR_W-1:0] power;
	} poly_rsp_t;

	// clamp the incoming duration to DURATION_BITS
	function automatic logic [DUR_W-1:0] sat_dur(input logic [IN_DUR_W-1:0] d);
		logic [32:0] dw;
		logic [32:0] maxv;
		dw   = 33'(d);
		maxv = (33'd1 << DURATION_BITS) - 33'd1;
		return (dw > maxv) ? DUR_W'(maxv) : DUR_W'(dw);
	endfunction

endpackage

// ===== src/crp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_if: valid/ready channels of the cadence and power meter
// crp_in_if carries one sensor event item, crp_out_if one result item.
// ----------------------------------------------------------------------------
interface crp_in_if;
	import crp_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [IN_DUR_W-1:0] duration_ms;
	logic                up_level;
	logic                down_level;

	modport source (output valid, output cmd, output duration_ms, output up_level,
		output down_level, input ready);
	modport sink (input valid, input cmd, input duration_ms, input up_level,
		input down_level, output ready);
endinterface

interface crp_out_if;
	import crp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    report;
	logic [RPM_W-1:0]        rpm;
	logic signed [PWR_W-1:0] power_watts;
	logic [RES_OUT_W-1:0]    resistance_level;
	logic signed [DIR_W-1:0] change_direction;
	logic [CNT_W-1:0]        crank_total;

	modport source (output valid, output report, output rpm, output power_watts,
		output resistance_level, output change_direction, output crank_total,
		input ready);
	modport sink (input valid, input report, input rpm, input power_watts,
		input resistance_level, input change_direction, input crank_total,
		output ready);
endinterface

// ===== src/crp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_div: iterative cadence divider
// Restoring division of the fixed cadence numerator by the period sum,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  crp_pkg::div_req_t req,
	output crp_pkg::div_rsp_t rsp
);
	import crp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RPM_W-1:0]     dvd_q;
	logic [RPM_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W:0]       rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, dvd_q[RPM_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(RPM_W - 1);
		end else if (busy_q) begin
			busy_q <= (cnt_q != '0);
			done_q <= (cnt_q == '0);
			cnt_q  <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= RPM_W'(RPM_NUM);
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits DIV_W bits
			rem_q <= fits ? DIV_W'(rem_sh - {1'b0, dsr_q}) : DIV_W'(rem_sh);
			quo_q <= {quo_q[RPM_W-2:0], fits};
			dvd_q <= {dvd_q[RPM_W-2:0], 1'b0};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/crp_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_poly: power polynomial on one shared multiplier
// p = r^2*(C_LR2*l + C_R2) + r*(C_LR*l + C_R) + l*(C_L2*l + C_L) + C_C,
// seven multiply steps, then Q24 truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module crp_poly (
	input  logic               clk,
	input  logic               arst_n,
	input  crp_pkg::poly_req_t req,
	output crp_pkg::poly_rsp_t rsp
);
	import crp_pkg::*;

	poly_state_t state_q, state_d;
	poly_step_t  step_q, step_d;
	logic        done_q;

	logic [RES_W-1:0]         l_q;
	logic [RPM_W-1:0]         r_q;
	logic [2*RPM_W-1:0]       r2_q;
	logic signed [TMP_W-1:0]  tmp_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]         mag_q;
	logic                     neg_q;
	logic signed [PWR_W-1:0]  power_q;

	logic signed [OPA_W-1:0]  opa;
	logic signed [OPB_W-1:0]  opb;
	logic [QUO_W-1:0]         qmag;
	logic signed [PWR_W-1:0]  power_sat;

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			PS_IDLE: begin
				if (req.start) begin
					state_d = PS_MUL;
					step_d  = ST_R2;
				end
			end
			PS_MUL: state_d = PS_ACC;
			PS_ACC: begin
				unique case (step_q)
					ST_R2: step_d = ST_A2;
					ST_A2: step_d = ST_T2;
					ST_T2: step_d = ST_A1;
					ST_A1: step_d = ST_T1;
					ST_T1: step_d = ST_A0;
					ST_A0: step_d = ST_T0;
					ST_T0: step_d = ST_R2;
				endcase
				state_d = (step_q == ST_T0) ? PS_CONST : PS_MUL;
			end
			PS_CONST: state_d = PS_ABS;
			PS_ABS:   state_d = PS_SAT;
			PS_SAT:   state_d = PS_IDLE;
			default:  state_d = PS_IDLE;
		endcase
	end

	// multiplier operands for the current step
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (step_q)
			ST_R2: begin
				opa = $signed({{(OPA_W-RPM_W){1'b0}}, r_q});
				opb = $signed({{(OPB_W-RPM_W){1'b0}}, r_q});
			end
			ST_A2: begin
				opa = OPA_W'(C_LR2);
				opb = $signed({{(OPB_W-RES_W){1'b0}}, l_q});
			end
			ST_T2: begin
				opa = $signed({{(OPA_W-2*RPM_W){1'b0}}, r2_q});
				opb = tmp_q;
			end
			ST_A1: begin
				opa = OPA_W'(C_LR);
				opb = $signed({{(OPB_W-RES_W){1'b0}}, l_q});
			end
			ST_T1: begin
				opa = OPA_W'(tmp_q);
				opb = $signed({{(OPB_W-RPM_W){1'b0}}, r_q});
			end
			ST_A0: begin
				opa = OPA_W'(C_L2);
				opb = $signed({{(OPB_W-RES_W){1'b0}}, l_q});
			end
			ST_T0: begin
				opa = OPA_W'(tmp_q);
				opb = $signed({{(OPB_W-RES_W){1'b0}}, l_q});
			end
		endcase
	end

	// magnitude already truncated; restore sign and clamp
	always_comb begin
		qmag = mag_q[ACC_W-1:FRAC_BITS];
		if (neg_q)
			power_sat = (qmag > PWR_NEG_LIM) ? PWR_MIN : PWR_W'(QUO_W'(0) - qmag);
		else
			power_sat = (qmag > PWR_POS_LIM) ? PWR_MAX : PWR_W'(qmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			step_q  <= ST_R2;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			done_q  <= (state_q == PS_SAT);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			l_q <= req.level;
			r_q <= req.rpm;
		end
		unique case (state_q)
			PS_IDLE: ;
			PS_MUL: prod_s1 <= opa * opb;
			PS_ACC: begin
				unique case (step_q)
					ST_R2: r2_q  <= prod_s1[2*RPM_W-1:0];
					ST_A2: tmp_q <= TMP_W'(prod_s1 + PROD_W'(C_R2));
					ST_T2: acc_q <= ACC_W'(prod_s1);
					ST_A1: tmp_q <= TMP_W'(prod_s1 + PROD_W'(C_R));
					ST_T1: acc_q <= acc_q + ACC_W'(prod_s1);
					ST_A0: tmp_q <= TMP_W'(prod_s1 + PROD_W'(C_L));
					ST_T0: acc_q <= acc_q + ACC_W'(prod_s1);
				endcase
			end
			PS_CONST: acc_q <= acc_q + ACC_W'(C_C);
			PS_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
			end
			PS_SAT: power_q <= power_sat;
			default: ;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.power = power_q;

endmodule

// ===== src/trainer_cadence_power_meter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trainer_cadence_power_meter_top: cadence and power meter for a trainer bike
//
//   port      dir   item
//   events    sink  cmd, duration_ms, up_level, down_level
//   results   src   report, rpm, power_watts, resistance_level,
//                   change_direction, crank_total
//
// One result item per event item. Non-crank events go straight from
// accept to the result; a counted crank passes through the bit-serial
// divider and then the multiplier sequence before its result is loaded.
// One item in flight; events.ready is low until its result is registered.
// A stalled result holds in the output register; the next item is taken
// meanwhile. Reset clears all tracked state; no clearing pass.
// ----------------------------------------------------------------------------
module trainer_cadence_power_meter_top (
	input  logic      clk,
	input  logic      arst_n,
	crp_in_if.sink    events,
	crp_out_if.source results
);
	import crp_pkg::*;

	top_state_t state_q, state_d;

	logic [DUR_W-1:0]        high_q;
	logic [DUR_W-1:0]        low_q;
	logic [RES_W-1:0]        res_q;
	logic [DIR_W-1:0]        dir_q;
	logic [CNT_W-1:0]        crank_q;
	logic signed [PWR_W-1:0] power_q;
	logic [RPM_W-1:0]        rpm_q;
	logic                    report_q;
	logic                    out_valid_q;

	logic                    out_report_q;
	logic [RPM_W-1:0]        out_rpm_q;
	logic signed [PWR_W-1:0] out_power_q;
	logic [RES_OUT_W-1:0]    out_res_q;
	logic [DIR_W-1:0]        out_dir_q;
	logic [CNT_W-1:0]        out_crank_q;

	logic             accept;
	logic             out_load;
	cmd_t             cmd;
	logic [DUR_W-1:0] dur;
	logic             crank_hit;
	logic [DIV_W-1:0] period_sum;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	poly_req_t poly_req;
	poly_rsp_t poly_rsp;

	assign accept     = events.valid && events.ready;
	assign cmd        = cmd_t'(events.cmd);
	assign dur        = sat_dur(events.duration_ms);
	assign crank_hit  = (cmd == CMD_WHEEL_FELL) && (dur != high_q);
	assign period_sum = DIV_W'(dur) + DIV_W'(low_q);

	// zero period sum divides by one
	assign div_req.start   = accept && crank_hit;
	assign div_req.divisor = (period_sum == '0) ? DIV_W'(1) : period_sum;

	assign poly_req.start = div_rsp.done;
	assign poly_req.level = res_q;
	assign poly_req.rpm   = div_rsp.quotient;

	crp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	crp_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (poly_req),
		.rsp    (poly_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: if (accept) state_d = crank_hit ? TS_DIV : TS_DONE;
			TS_DIV:  if (div_rsp.done) state_d = TS_POLY;
			TS_POLY: if (poly_rsp.done) state_d = TS_DONE;
			TS_DONE: if (out_load) state_d = TS_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		events.ready = (state_q == TS_IDLE);
		out_load     = (state_q == TS_DONE) && (!out_valid_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			high_q      <= '0;
			low_q       <= '0;
			res_q       <= '0;
			dir_q       <= DIR_NONE;
			crank_q     <= '0;
			power_q     <= '0;
			rpm_q       <= '0;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				report_q <= crank_hit;
				rpm_q    <= '0;
				unique case (cmd)
					CMD_WHEEL_FELL: begin
						if (crank_hit) begin
							crank_q <= crank_q + 1'b1;
							high_q  <= dur;
						end
					end
					CMD_WHEEL_ROSE: low_q <= dur;
					CMD_SWITCH: begin
						// both low keeps the direction
						if (events.up_level != events.down_level)
							dir_q <= events.down_level ? DIR_UP : DIR_DOWN;
						else if (events.up_level)
							dir_q <= DIR_NONE;
					end
					CMD_MOTOR: begin
						if (dir_q == DIR_DOWN && res_q != '0)
							res_q <= res_q - 1'b1;
						else if (dir_q == DIR_UP && res_q < RES_W'(RESISTANCE_MAX))
							res_q <= res_q + 1'b1;
					end
				endcase
			end
			if (div_rsp.done)
				rpm_q <= div_rsp.quotient;
			if (poly_rsp.done)
				power_q <= poly_rsp.power;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_report_q <= report_q;
			out_rpm_q    <= rpm_q;
			out_power_q  <= power_q;
			out_res_q    <= RES_OUT_W'(res_q);
			out_dir_q    <= dir_q;
			out_crank_q  <= crank_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.report           = out_report_q;
	assign results.rpm              = out_rpm_q;
	assign results.power_watts      = out_power_q;
	assign results.resistance_level = out_res_q;
	assign results.change_direction = out_dir_q;
	assign results.crank_total      = out_crank_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !events.ready)
		else $error("block ready right after taking an item");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= RES_W'(RESISTANCE_MAX))
		else $error("resistance above its maximum");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == TS_DIV)
		else $error("divider finished outside the divide phase");

	a_poly_state: assert property (@(posedge clk) disable iff (!arst_n)
		poly_rsp.done |-> state_q == TS_POLY)
		else $error("power unit finished outside the power phase");

	a_rpm_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !report_q |-> rpm_q == '0)
		else $error("nonzero cadence without a crank");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the trainer cadence and power meter
// Queues sensor event items into a valid/ready driver. An item-level predictor
// tracks wheel periods, crank count, resistance, direction and power. A monitor
// compares every result item field by field against the predicted readings.
// Random idle bursts are used on both channels, and one long result hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	import crp_pkg::*;

	typedef struct {
		cmd_t                cmd;
		logic [IN_DUR_W-1:0] duration_ms;
		logic                up_level;
		logic                down_level;
	} sensor_item_t;

	typedef struct {
		logic                    report;
		logic [RPM_W-1:0]        rpm;
		logic signed [PWR_W-1:0] power_watts;
		logic [RES_OUT_W-1:0]    resistance_level;
		logic signed [DIR_W-1:0] change_direction;
		logic [CNT_W-1:0]        crank_total;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	crp_in_if  events_bus ();
	crp_out_if results_bus ();

	trainer_cadence_power_meter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events_bus),
		.results (results_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted meter state
	logic [DUR_W-1:0]        high_ms    = '0;
	logic [DUR_W-1:0]        low_ms     = '0;
	int unsigned             load_steps = 0;
	logic signed [DIR_W-1:0] step_dir   = DIR_NONE;
	logic [CNT_W-1:0]        crank_cnt  = '0;
	logic signed [PWR_W-1:0] watts      = '0;

	sensor_item_t   sensor_q[$];
	meter_reading_t readings_q[$];
	int unsigned    items_queued   = 0;
	int unsigned    mismatch_count = 0;

	bit          src_idling  = 1'b1;
	bit          sink_idling = 1'b1;
	int unsigned holds_asked = 0;
	int unsigned holds_given = 0;
	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	int unsigned hold_left   = 0;
	logic        in_taken    = 1'b0;

	function automatic logic signed [PWR_W-1:0] estimate_watts(longint lvl, longint cad);
		longint acc;
		longint q;
		acc = longint'(C_LR2) * lvl * cad * cad + longint'(C_R2) * cad * cad
			+ longint'(C_L2) * lvl * lvl + longint'(C_LR) * lvl * cad
			+ longint'(C_R) * cad + longint'(C_L) * lvl + longint'(C_C);
		// signed divide truncates toward zero
		q = acc / (longint'(1) << FRAC_BITS);
		if (q > longint'(PWR_MAX))
			q = longint'(PWR_MAX);
		if (q < longint'(PWR_MIN))
			q = longint'(PWR_MIN);
		return PWR_W'(q);
	endfunction

	function automatic meter_reading_t predict_reading(sensor_item_t it);
		meter_reading_t r;
		longint unsigned dmax;
		longint unsigned dur;
		longint unsigned span;
		dmax = (64'd1 << DURATION_BITS) - 64'd1;
		dur = (64'(it.duration_ms) > dmax) ? dmax : 64'(it.duration_ms);
		r.report = 1'b0;
		r.rpm = '0;
		case (it.cmd)
		CMD_WHEEL_FELL: begin
			// an unchanged high time is not a new crank
			if (DUR_W'(dur) != high_ms) begin
				crank_cnt = crank_cnt + 1'b1;
				high_ms = DUR_W'(dur);
				span = 64'(high_ms) + 64'(low_ms);
				if (span == 0)
					span = 1;
				r.rpm = RPM_W'(RPM_NUM / span);
				watts = estimate_watts(longint'(load_steps), longint'(r.rpm));
				r.report = 1'b1;
			end
		end
		CMD_WHEEL_ROSE: begin
			low_ms = DUR_W'(dur);
		end
		CMD_SWITCH: begin
			if (it.up_level != it.down_level)
				step_dir = (it.down_level == 1'b0) ? DIR_DOWN : DIR_UP;
			else if (it.up_level)
				step_dir = DIR_NONE;
		end
		default: begin
			if (step_dir == DIR_DOWN && load_steps > 0)
				load_steps = load_steps - 1;
			else if (step_dir == DIR_UP && load_steps < RESISTANCE_MAX)
				load_steps = load_steps + 1;
		end
		endcase
		r.power_watts = watts;
		r.resistance_level = RES_OUT_W'(load_steps);
		r.change_direction = step_dir;
		r.crank_total = crank_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// sender: new item or idle burst once the previous one is gone
	always @(negedge clk) begin
		sensor_item_t nxt;
		if (arst_n) begin
			if (!events_bus.valid || in_taken) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					events_bus.valid <= 1'b0;
				end else if (src_idling && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 16);
					events_bus.valid <= 1'b0;
				end else if (sensor_q.size() != 0) begin
					nxt = sensor_q.pop_front();
					events_bus.valid <= 1'b1;
					events_bus.cmd <= nxt.cmd;
					events_bus.duration_ms <= nxt.duration_ms;
					events_bus.up_level <= nxt.up_level;
					events_bus.down_level <= nxt.down_level;
				end else begin
					events_bus.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long hold-off on request, otherwise random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				results_bus.ready <= 1'b0;
			end else if (holds_asked != holds_given) begin
				hold_left <= 299;
				holds_given <= holds_given + 1;
				results_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				results_bus.ready <= 1'b0;
			end else if (sink_idling && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		meter_reading_t want;
		meter_reading_t got;
		sensor_item_t acc_item;
		if (arst_n) begin
			in_taken <= events_bus.valid && events_bus.ready;
			if (results_bus.valid && results_bus.ready) begin
				got.report = results_bus.report;
				got.rpm = results_bus.rpm;
				got.power_watts = results_bus.power_watts;
				got.resistance_level = results_bus.resistance_level;
				got.change_direction = results_bus.change_direction;
				got.crank_total = results_bus.crank_total;
				if (readings_q.size() == 0) begin
					report_mismatch("result item with no reading pending");
				end else begin
					want = readings_q.pop_front();
					if (got.report !== want.report)
						report_mismatch($sformatf("report want %0b got %0b",
							want.report, got.report));
					if (got.rpm !== want.rpm)
						report_mismatch($sformatf("rpm want %0d got %0d", want.rpm, got.rpm));
					if (got.power_watts !== want.power_watts)
						report_mismatch($sformatf("power_watts want %0d got %0d",
							want.power_watts, got.power_watts));
					if (got.resistance_level !== want.resistance_level)
						report_mismatch($sformatf("resistance_level want %0d got %0d",
							want.resistance_level, got.resistance_level));
					if (got.change_direction !== want.change_direction)
						report_mismatch($sformatf("change_direction want %0d got %0d",
							want.change_direction, got.change_direction));
					if (got.crank_total !== want.crank_total)
						report_mismatch($sformatf("crank_total want %0d got %0d",
							want.crank_total, got.crank_total));
				end
			end
			if (events_bus.valid && events_bus.ready) begin
				acc_item.cmd = cmd_t'(events_bus.cmd);
				acc_item.duration_ms = events_bus.duration_ms;
				acc_item.up_level = events_bus.up_level;
				acc_item.down_level = events_bus.down_level;
				readings_q.push_back(predict_reading(acc_item));
			end
		end
	end

	task automatic push_item(cmd_t c, logic [IN_DUR_W-1:0] d, logic up, logic down);
		sensor_item_t it;
		it.cmd = c;
		it.duration_ms = d;
		it.up_level = up;
		it.down_level = down;
		sensor_q.push_back(it);
		items_queued++;
	endtask

	task automatic push_pedal(logic [IN_DUR_W-1:0] lo, logic [IN_DUR_W-1:0] hi);
		push_item(CMD_WHEEL_ROSE, lo, 1'($urandom), 1'($urandom));
		push_item(CMD_WHEEL_FELL, hi, 1'($urandom), 1'($urandom));
	endtask

	// mostly pedal strokes and switch/motor runs, some raw noise
	task automatic push_random(int unsigned n);
		int unsigned first;
		int unsigned pick;
		logic [IN_DUR_W-1:0] lo;
		logic [IN_DUR_W-1:0] hi;
		logic [IN_DUR_W-1:0] last_high;
		first = items_queued;
		last_high = '0;
		while (items_queued - first < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				lo = ($urandom_range(0, 9) == 0) ? IN_DUR_W'($urandom) :
					IN_DUR_W'($urandom_range(100, 1500));
				if (pick < 5)
					hi = last_high;
				else if (pick < 12)
					hi = IN_DUR_W'($urandom);
				else
					hi = IN_DUR_W'($urandom_range(100, 1500));
				push_pedal(lo, hi);
				last_high = hi;
			end else if (pick < 75) begin
				push_item(CMD_SWITCH, IN_DUR_W'($urandom), 1'($urandom), 1'($urandom));
				repeat ($urandom_range(1, 10))
					push_item(CMD_MOTOR, IN_DUR_W'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				push_item(cmd_t'($urandom_range(0, 3)), IN_DUR_W'($urandom),
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	// resistance run in one direction to its end stop, with fast strokes along the way
	task automatic push_ramp(logic up, logic down);
		push_item(CMD_SWITCH, '0, up, down);
		for (int i = 0; i < 270; i++) begin
			push_item(CMD_MOTOR, IN_DUR_W'($urandom), 1'($urandom), 1'($urandom));
			if (i % 45 == 0)
				push_pedal(IN_DUR_W'($urandom_range(0, 30)), IN_DUR_W'($urandom_range(1, 30)));
		end
	endtask

	task automatic wait_sent();
		while (sensor_q.size() != 0 || events_bus.valid)
			@(posedge clk);
	endtask

	initial begin
		events_bus.valid = 1'b0;
		events_bus.cmd = '0;
		events_bus.duration_ms = '0;
		events_bus.up_level = 1'b0;
		events_bus.down_level = 1'b0;
		results_bus.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed
		push_item(CMD_WHEEL_FELL, 16'd0, 1'b0, 1'b1);       // same high time as reset
		push_item(CMD_SWITCH, 16'd0, 1'b1, 1'b1);           // both high: stop (already stopped)
		push_item(CMD_SWITCH, 16'd0, 1'b0, 1'b1);           // up pressed
		repeat (3) push_item(CMD_MOTOR, 16'd0, 1'b1, 1'b0);
		push_item(CMD_WHEEL_ROSE, 16'd0, 1'b1, 1'b1);
		push_item(CMD_WHEEL_FELL, 16'd1, 1'b0, 1'b0);       // 60000 rpm
		push_item(CMD_WHEEL_FELL, 16'd0, 1'b1, 1'b0);       // zero period sum
		push_item(CMD_WHEEL_ROSE, 16'hFFFF, 1'b0, 1'b1);
		push_item(CMD_WHEEL_FELL, 16'hFFFF, 1'b1, 1'b1);    // rpm rounds to 0
		push_item(CMD_WHEEL_FELL, 16'hFFFF, 1'b0, 1'b0);    // unchanged high time
		push_item(CMD_SWITCH, 16'hFFFF, 1'b1, 1'b0);        // down pressed
		repeat (4) push_item(CMD_MOTOR, 16'h0000, 1'b0, 1'b1);  // clamp at zero
		push_item(CMD_SWITCH, 16'h5A5A, 1'b0, 1'b0);        // both low: keep
		push_item(CMD_MOTOR, 16'hA5A5, 1'b1, 1'b1);
		push_item(CMD_SWITCH, 16'h0000, 1'b1, 1'b1);        // both high: stop
		push_item(CMD_MOTOR, 16'hFFFF, 1'b0, 1'b0);
		push_item(CMD_WHEEL_ROSE, 16'd400, 1'b1, 1'b1);
		push_item(CMD_WHEEL_FELL, 16'd600, 1'b0, 1'b1);
		wait_sent();

		push_random(500);
		wait_sent();

		// fill the queue, then hold results off so the input stalls
		push_ramp(1'b0, 1'b1);
		push_ramp(1'b1, 1'b0);
		holds_asked++;
		wait_sent();

		src_idling = 1'b0;
		push_random(500);
		wait_sent();

		sink_idling = 1'b0;
		push_random(300);
		wait_sent();

		while (readings_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
